// ===== sv/bmpd_pkg.sv =====
// shared types, constants and helpers for the bmp pixel stream decoder
`default_nettype none
package bmpd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // header layout, byte positions in the file
  localparam logic [5:0] OFS_POS      = 6'd10;
  localparam logic [5:0] WID_POS      = 6'd18;
  localparam logic [5:0] HGT_POS      = 6'd22;
  localparam logic [5:0] BPP_POS      = 6'd28;
  localparam logic [5:0] CMP_POS      = 6'd30;
  localparam logic [5:0] LAST_HDR_POS = 6'd53;
  localparam logic [31:0] HDR_LEN     = 32'd54;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4D;

  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_MAGIC       = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_OFFSET      = 3'd4,
    ST_TRUNCATED   = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] pix_row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_of_run;
  } result_t;

  function automatic result_t mk_res(status_t st, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic [11:0] col,
                                     logic [11:0] row, logic [12:0] w,
                                     logic [12:0] h);
    result_t res;
    res.status       = st;
    res.red          = r;
    res.green        = g;
    res.blue         = b;
    res.column       = col;
    res.pix_row      = row;
    res.image_width  = w;
    res.image_height = h;
    res.last_of_run  = 1'b0;
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bmpd_res_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high
`default_nettype none
module bmpd_res_fifo
  import bmpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push0,
  input  wire logic    push1,
  input  wire result_t din0,
  input  wire result_t din1,
  output logic         space2,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      dout
);

  localparam int unsigned PW = $clog2(RES_DEPTH);
  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  result_t mem [RES_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign dout      = mem[rd_ptr_r];
  assign space2    = cnt_r <= CW'(RES_DEPTH - 2);
  assign n_push    = {1'b0, push0} + {1'b0, push1};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_r + PW'(1)] <= din1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bmp_pixel_stream_decoder.sv =====
// bmp decoder: one file byte per beat in, rgb pixels and status beats out
// results of an accepted byte are registered in the result queue and can reach the output in the following cycle
// throughput: one byte per cycle while the result queue has room for two results;
// a byte with two results is absorbed by the four-entry result queue
// reset: synchronous active-low rst_n returns to awaiting header and empties
// the queue; every end_of_file byte also re-arms the decoder
`default_nettype none
module bmp_pixel_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [11:0]      out_column,
  output logic [11:0]      out_pix_row,
  output logic [12:0]      out_image_width,
  output logic [12:0]      out_image_height,
  output logic             out_last_of_run
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(4 * MAX_WIDTH + 1);

  localparam logic [1:0] LANE_RED   = 2'd2;
  localparam logic [1:0] LANE_ALPHA = 2'd3;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXELS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_FAILED = 5'b10000
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [31:0]   ofs_r, ofs_nxt, wid_r, wid_nxt, hgt_r, hgt_nxt, cmp_r, cmp_nxt;
  logic [15:0]   bpp_r, bpp_nxt;
  logic [7:0]    blue_r, blue_nxt, green_r, green_nxt;
  logic [RW-1:0] bir_r, bir_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [WW-1:0] col_r, col_nxt;
  logic [HW-1:0] rc_r, rc_nxt;

  // header figures worked out ahead of the last header byte
  logic          hdr_ok_r, top_r, ofs_small_r, ofs_exact_r, wide_px_r;
  logic [HW-1:0] abs_h_r;
  logic [RW-1:0] pix_bytes_r, row_len_r;

  logic [31:0]   abs_full;
  logic [WW-1:0] w_n;
  logic [RW:0]   pix_sum, row_sum;

  logic          acc_beat;
  logic [5:0]    pos6;
  logic [1:0]    lane;
  logic [RW:0]   bir_inc;
  logic [HW:0]   rc_inc;
  logic          in_px, row_end, last_row, bip_last;
  logic [HW-1:0] dest;
  logic [31:0]   col32, row32, h32;
  logic [12:0]   w13, h13;
  logic          a_vld, b_vld, push0, push1, space2;
  result_t       res_a, res_b, din0, din1, dout;

  assign acc_beat = in_valid && in_ready;
  assign in_ready = space2;

  always_comb begin
    abs_full = hgt_r[31] ? (32'd0 - hgt_r) : hgt_r;
    w_n      = wid_r[WW-1:0];
    if (bpp_r == BPP_32) begin
      pix_sum = (RW+1)'({w_n, 2'b00});
    end else begin
      pix_sum = (RW+1)'({w_n, 1'b0}) + (RW+1)'(w_n);
    end
    row_sum = pix_sum + (RW+1)'(3);
  end

  always_ff @(posedge clk) begin
    hdr_ok_r    <= cmp_r == 32'd0 && (bpp_r == BPP_24 || bpp_r == BPP_32) &&
                   wid_r != 32'd0 && !wid_r[31] && wid_r <= 32'(MAX_WIDTH) &&
                   abs_full != 32'd0 && abs_full <= 32'(MAX_HEIGHT);
    top_r       <= hgt_r[31];
    ofs_small_r <= ofs_r < HDR_LEN;
    ofs_exact_r <= ofs_r == HDR_LEN;
    wide_px_r   <= bpp_r == BPP_32;
    abs_h_r     <= abs_full[HW-1:0];
    pix_bytes_r <= pix_sum[RW-1:0];
    row_len_r   <= {row_sum[RW-1:2], 2'b00};
  end

  always_comb begin
    pos6     = pos_r[5:0];
    bir_inc  = {1'b0, bir_r} + (RW+1)'(1);
    rc_inc   = {1'b0, rc_r} + (HW+1)'(1);
    in_px    = bir_r < pix_bytes_r;
    row_end  = bir_inc >= {1'b0, row_len_r};
    last_row = rc_inc >= {1'b0, abs_h_r};
    bip_last = wide_px_r ? (bip_r == LANE_ALPHA) : (bip_r == LANE_RED);
    dest     = top_r ? rc_r : (abs_h_r - HW'(1) - rc_r);
    col32    = 32'(col_r);
    row32    = 32'(dest);
    h32      = 32'(abs_h_r);
    w13      = wid_r[12:0];
    h13      = h32[12:0];
    lane     = 2'b00;
  
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ofs_nxt   = ofs_r;
    wid_nxt   = wid_r;
    hgt_nxt   = hgt_r;
    cmp_nxt   = cmp_r;
    bpp_nxt   = bpp_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    bir_nxt   = bir_r;
    bip_nxt   = bip_r;
    col_nxt   = col_r;
    rc_nxt    = rc_r;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    res_a     = mk_res(ST_PIXEL, '0, '0, '0, '0, '0, '0, '0);
    res_b     = mk_res(ST_PIXEL, '0, '0, '0, '0, '0, '0, '0);

    unique case (phase_r)
      PH_HEADER: begin
        if ((pos6 == 6'd0 && in_data_byte != MAGIC_B) ||
            (pos6 == 6'd1 && in_data_byte != MAGIC_M)) begin
          a_vld     = 1'b1;
          res_a     = mk_res(ST_MAGIC, '0, '0, '0, '0, '0, '0, '0);
          phase_nxt = PH_FAILED;
        end else begin
          pos_nxt = pos_r + 32'd1;
          if (pos6 >= OFS_POS && pos6 < OFS_POS + 6'd4) begin
            lane = 2'(pos6 - OFS_POS);
            ofs_nxt[{lane, 3'b000} +: 8] = in_data_byte;
          end else if (pos6 >= WID_POS && pos6 < WID_POS + 6'd4) begin
            lane = 2'(pos6 - WID_POS);
            wid_nxt[{lane, 3'b000} +: 8] = in_data_byte;
          end else if (pos6 >= HGT_POS && pos6 < HGT_POS + 6'd4) begin
            lane = 2'(pos6 - HGT_POS);
            hgt_nxt[{lane, 3'b000} +: 8] = in_data_byte;
          end else if (pos6 >= BPP_POS && pos6 < BPP_POS + 6'd2) begin
            lane = 2'(pos6 - BPP_POS);
            bpp_nxt[{lane[0], 3'b000} +: 8] = in_data_byte;
          end else if (pos6 >= CMP_POS && pos6 < CMP_POS + 6'd4) begin
            lane = 2'(pos6 - CMP_POS);
            cmp_nxt[{lane, 3'b000} +: 8] = in_data_byte;
          end
          if (pos6 == LAST_HDR_POS) begin
            priority if (!hdr_ok_r) begin
              a_vld     = 1'b1;
              res_a     = mk_res(ST_UNSUPPORTED, '0, '0, '0, '0, '0, '0, '0);
              phase_nxt = PH_FAILED;
            end else if (ofs_small_r) begin
              a_vld     = 1'b1;
              res_a     = mk_res(ST_OFFSET, '0, '0, '0, '0, '0, '0, '0);
              phase_nxt = PH_FAILED;
            end else begin
              bir_nxt   = '0;
              bip_nxt   = '0;
              col_nxt   = '0;
              rc_nxt    = '0;
              phase_nxt = ofs_exact_r ? PH_PIXELS : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_r + 32'd1;
        if (pos_nxt >= ofs_r) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (in_px) begin
          unique case (bip_r)
            2'd0: blue_nxt = in_data_byte;
            2'd1: green_nxt = in_data_byte;
            LANE_RED: begin
              a_vld   = 1'b1;
              res_a   = mk_res(ST_PIXEL, in_data_byte, green_r, blue_r,
                               col32[11:0], row32[11:0], w13, h13);
              col_nxt = col_r + WW'(1);
            end
            default: ;
          endcase
          bip_nxt = bip_last ? 2'd0 : bip_r + 2'd1;
        end
        bir_nxt = bir_inc[RW-1:0];
        if (row_end) begin
          bir_nxt = '0;
          bip_nxt = '0;
          col_nxt = '0;
          rc_nxt  = rc_inc[HW-1:0];
          if (last_row) begin
            phase_nxt = PH_DONE;
            b_vld     = 1'b1;
            res_b     = mk_res(ST_COMPLETE, '0, '0, '0, '0, '0, w13, h13);
          end
        end
      end
      PH_DONE, PH_FAILED: ;
      default: ;
    endcase

    if (in_end_of_file) begin
      if (phase_nxt == PH_HEADER || phase_nxt == PH_SKIP ||
          phase_nxt == PH_PIXELS) begin
        b_vld = 1'b1;
        if (phase_nxt == PH_HEADER) begin
          res_b = mk_res(ST_TRUNCATED, '0, '0, '0, '0, '0, '0, '0);
        end else begin
          res_b = mk_res(ST_TRUNCATED, '0, '0, '0, '0, '0, w13, h13);
        end
      end
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      ofs_nxt   = '0;
      wid_nxt   = '0;
      hgt_nxt   = '0;
      cmp_nxt   = '0;
      bpp_nxt   = '0;
      bir_nxt   = '0;
      bip_nxt   = '0;
      col_nxt   = '0;
      rc_nxt    = '0;
    end
  end

  // pack the two possible results into queue order and mark the last one
  always_comb begin
    if (a_vld) begin
      din0  = res_a;
      din1  = res_b;
      push0 = acc_beat;
      push1 = acc_beat && b_vld;
      din0.last_of_run = !b_vld;
      din1.last_of_run = 1'b1;
    end else begin
      din0  = res_b;
      din1  = res_b;
      push0 = acc_beat && b_vld;
      push1 = 1'b0;
      din0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      bir_r   <= '0;
      bip_r   <= '0;
      col_r   <= '0;
      rc_r    <= '0;
    end else if (acc_beat) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      bir_r   <= bir_nxt;
      bip_r   <= bip_nxt;
      col_r   <= col_nxt;
      rc_r    <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_beat) begin
      ofs_r   <= ofs_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      cmp_r   <= cmp_nxt;
      bpp_r   <= bpp_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

  bmpd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (din0),
    .din1      (din1),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign out_status       = 3'(dout.status);
  assign out_red          = dout.red;
  assign out_green        = dout.green;
  assign out_blue         = dout.blue;
  assign out_column       = dout.column;
  assign out_pix_row      = dout.pix_row;
  assign out_image_width  = dout.image_width;
  assign out_image_height = dout.image_height;
  assign out_last_of_run  = dout.last_of_run;

endmodule
`default_nettype wire

// ===== dv/tb_bmp_pixel_stream_decoder.sv =====
// testbench for the bmp pixel stream decoder: byte stream in, rgb and status beats checked
module tb_bmp_pixel_stream_decoder
  import bmpd_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 950;
  localparam int unsigned DEFECT_KINDS = 9;

  typedef enum logic [2:0] {
    HDR_PARSE,
    OFFSET_SKIP,
    PIXEL_DATA,
    IMAGE_DONE,
    FILE_FAILED
  } parse_phase_t;

  typedef enum int {
    FK_GOOD,
    FK_TRUNC,
    FK_MAGIC,
    FK_OFFSET,
    FK_BIG,
    FK_UNSUP
  } file_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    logic       has_beat;
    status_t    st;
  } stim_row_t;

  // typed rows carry their one beat (or none); untyped rows go through the decoder model
  localparam stim_row_t DIRECTED_ROWS [14] = '{
    '{8'h00,   1'b0, 1'b1, 1'b1, ST_MAGIC},
    '{8'hFF,   1'b1, 1'b1, 1'b0, ST_PIXEL},
    '{MAGIC_B, 1'b0, 1'b1, 1'b0, ST_PIXEL},
    '{8'hFF,   1'b0, 1'b1, 1'b1, ST_MAGIC},
    '{8'h00,   1'b0, 1'b1, 1'b0, ST_PIXEL},
    '{8'hA5,   1'b1, 1'b1, 1'b0, ST_PIXEL},
    '{MAGIC_B, 1'b1, 1'b1, 1'b1, ST_TRUNCATED},
    '{MAGIC_M, 1'b1, 1'b1, 1'b1, ST_MAGIC},
    '{MAGIC_B, 1'b0, 1'b1, 1'b0, ST_PIXEL},
    '{MAGIC_M, 1'b0, 1'b1, 1'b0, ST_PIXEL},
    '{8'hFF,   1'b0, 1'b0, 1'b0, ST_PIXEL},
    '{8'h00,   1'b0, 1'b0, 1'b0, ST_PIXEL},
    '{8'h5A,   1'b0, 1'b0, 1'b0, ST_PIXEL},
    '{8'h80,   1'b1, 1'b1, 1'b1, ST_TRUNCATED}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_column;
  logic [11:0] out_pix_row;
  logic [12:0] out_image_width;
  logic [12:0] out_image_height;
  logic        out_last_of_run;

  bmp_pixel_stream_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_column       (out_column),
    .out_pix_row      (out_pix_row),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder model state
  parse_phase_t dec_phase;
  logic [31:0]  file_pos;
  logic [31:0]  pix_ofs;
  logic [31:0]  wid_word;
  logic [31:0]  hgt_word;
  logic [15:0]  depth_word;
  logic [31:0]  cmp_word;
  logic         rows_top_first;
  logic [31:0]  row_len;
  logic [31:0]  row_cnt;
  logic [31:0]  row_byte;
  logic [31:0]  px_byte;
  logic [7:0]   held_b;
  logic [7:0]   held_g;

  result_t     byte_beats[$];
  result_t     awaited_beats[$];
  logic [7:0]  file_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  task automatic clear_decoder();
    dec_phase      = HDR_PARSE;
    file_pos       = '0;
    pix_ofs        = '0;
    wid_word       = '0;
    hgt_word       = '0;
    depth_word     = '0;
    cmp_word       = '0;
    rows_top_first = 1'b0;
    row_len        = '0;
    row_cnt        = '0;
    row_byte       = '0;
    px_byte        = '0;
    held_b         = '0;
    held_g         = '0;
  endtask

  function automatic logic [31:0] height_mag();
    return rows_top_first ? (32'd0 - hgt_word) : hgt_word;
  endfunction

  task automatic add_beat(input status_t st, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b, input logic [31:0] col,
                          input logic [31:0] row);
    result_t     beat;
    logic        hdr_ok;
    logic [31:0] mag;
    hdr_ok = (dec_phase == OFFSET_SKIP || dec_phase == PIXEL_DATA || dec_phase == IMAGE_DONE);
    mag = height_mag();
    beat.status       = st;
    beat.red          = r;
    beat.green        = g;
    beat.blue         = b;
    beat.column       = col[11:0];
    beat.pix_row      = row[11:0];
    beat.image_width  = hdr_ok ? wid_word[12:0] : 13'd0;
    beat.image_height = hdr_ok ? mag[12:0] : 13'd0;
    beat.last_of_run  = 1'b0;
    byte_beats.push_back(beat);
  endtask

  // expected beats of one file byte, left in byte_beats
  task automatic decode_file_byte(input logic [7:0] v, input logic eof);
    logic [31:0] pos;
    logic [31:0] mag;
    logic [31:0] per_px;
    result_t     tail;
    byte_beats.delete();
    case (dec_phase)
      HDR_PARSE: begin
        pos = file_pos;
        if ((pos == 0 && v != MAGIC_B) || (pos == 1 && v != MAGIC_M)) begin
          add_beat(ST_MAGIC, 0, 0, 0, 0, 0);
          dec_phase = FILE_FAILED;
        end else begin
          if (pos >= OFS_POS && pos < OFS_POS + 4) pix_ofs[(pos - OFS_POS) * 8 +: 8] = v;
          else if (pos >= WID_POS && pos < WID_POS + 4) wid_word[(pos - WID_POS) * 8 +: 8] = v;
          else if (pos >= HGT_POS && pos < HGT_POS + 4) hgt_word[(pos - HGT_POS) * 8 +: 8] = v;
          else if (pos >= BPP_POS && pos < BPP_POS + 2) depth_word[(pos - BPP_POS) * 8 +: 8] = v;
          else if (pos >= CMP_POS && pos < CMP_POS + 4) cmp_word[(pos - CMP_POS) * 8 +: 8] = v;
          file_pos = pos + 1;
          if (file_pos >= HDR_LEN) begin
            rows_top_first = hgt_word[31];
            mag = height_mag();
            if (cmp_word != 0 || !(depth_word == BPP_24 || depth_word == BPP_32) ||
                wid_word == 0 || wid_word[31] || wid_word > DEF_MAX_WIDTH ||
                mag == 0 || mag > DEF_MAX_HEIGHT) begin
              add_beat(ST_UNSUPPORTED, 0, 0, 0, 0, 0);
              dec_phase = FILE_FAILED;
            end else if (pix_ofs < HDR_LEN) begin
              add_beat(ST_OFFSET, 0, 0, 0, 0, 0);
              dec_phase = FILE_FAILED;
            end else begin
              row_len   = ((wid_word * depth_word + 31) / 32) * 4;
              row_cnt   = '0;
              row_byte  = '0;
              px_byte   = '0;
              dec_phase = (pix_ofs == HDR_LEN) ? PIXEL_DATA : OFFSET_SKIP;
            end
          end
        end
      end
      OFFSET_SKIP: begin
        file_pos = file_pos + 1;
        if (file_pos >= pix_ofs) dec_phase = PIXEL_DATA;
      end
      PIXEL_DATA: begin
        per_px = depth_word / 8;
        // padding bytes at the row end carry no color
        if (row_byte < wid_word * per_px) begin
          case (px_byte)
            0: held_b = v;
            1: held_g = v;
            2: add_beat(ST_PIXEL, v, held_g, held_b, row_byte / per_px,
                        rows_top_first ? row_cnt : height_mag() - 1 - row_cnt);
            default: ;
          endcase
          px_byte = (px_byte + 1 >= per_px) ? 32'd0 : px_byte + 1;
        end
        row_byte = row_byte + 1;
        if (row_byte >= row_len) begin
          row_byte = '0;
          px_byte  = '0;
          row_cnt  = row_cnt + 1;
          if (row_cnt >= height_mag()) begin
            dec_phase = IMAGE_DONE;
            add_beat(ST_COMPLETE, 0, 0, 0, 0, 0);
          end
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (dec_phase == HDR_PARSE || dec_phase == OFFSET_SKIP || dec_phase == PIXEL_DATA)
        add_beat(ST_TRUNCATED, 0, 0, 0, 0, 0);
      clear_decoder();
    end
    if (byte_beats.size() != 0) begin
      tail = byte_beats.pop_back();
      tail.last_of_run = 1'b1;
      byte_beats.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned idle;
    idle = calm_in ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_word(input logic [31:0] val, input int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(val[8 * k +: 8]);
  endtask

  task automatic push_random(input int n);
    for (int k = 0; k < n; k++) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic build_header(input logic [31:0] ofs, input logic [31:0] w,
                              input logic [31:0] h, input logic [15:0] depth,
                              input logic [31:0] comp);
    file_bytes.delete();
    file_bytes.push_back(MAGIC_B);
    file_bytes.push_back(MAGIC_M);
    push_random(8);
    push_word(ofs, 4);
    push_random(4);
    push_word(w, 4);
    push_word(h, 4);
    push_random(2);
    push_word({16'h0000, depth}, 2);
    push_word(comp, 4);
    push_random(20);
  endtask

  // sends file_bytes up to and including the byte marked end of file
  task automatic send_file(input int cut);
    for (int i = 0; i <= cut; i++) begin
      send_byte(file_bytes[i], i == cut);
      decode_file_byte(file_bytes[i], i == cut);
      foreach (byte_beats[k]) awaited_beats.push_back(byte_beats[k]);
    end
  endtask

  // result side: a stall drawn before every beat
  initial begin
    int unsigned idle;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      idle = calm_out ? 0 : $urandom_range(0, 12);
      if (idle != 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("unexpected beat, status", out_status, -1);
      end else begin
        want = awaited_beats.pop_front();
        check_field("status", out_status, want.status);
        check_field("red", out_red, want.red);
        check_field("green", out_green, want.green);
        check_field("blue", out_blue, want.blue);
        check_field("column", out_column, want.column);
        check_field("pix_row", out_pix_row, want.pix_row);
        check_field("image_width", out_image_width, want.image_width);
        check_field("image_height", out_image_height, want.image_height);
        check_field("last_of_run", out_last_of_run, want.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    result_t     typed_beat;
    file_kind_t  kind;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] ofs;
    logic [31:0] comp;
    logic [15:0] depth;
    logic [7:0]  b;
    int          mag;
    int          row_bytes;
    int          cut;
    int          pick;
    int unsigned file_count;
    int unsigned unsup_count;
    int unsigned sent_bytes;

    clear_decoder();
    file_count  = 0;
    unsup_count = 0;
    sent_bytes  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      send_byte(row.data, row.eof);
      decode_file_byte(row.data, row.eof);
      if (row.typed) begin
        if (row.has_beat) begin
          typed_beat = '0;
          typed_beat.status = row.st;
          typed_beat.last_of_run = 1'b1;
          awaited_beats.push_back(typed_beat);
        end
      end else begin
        foreach (byte_beats[k]) awaited_beats.push_back(byte_beats[k]);
      end
    end

    while (sent_bytes < RANDOM_BYTES || unsup_count < DEFECT_KINDS) begin
      // each file kind once, then every header defect, then a mix weighted
      // toward well-formed images
      if (file_count < 6) begin
        kind = file_kind_t'(file_count);
      end else if (unsup_count < DEFECT_KINDS) begin
        kind = FK_UNSUP;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = FK_GOOD;
        else if (pick < 55) kind = FK_TRUNC;
        else if (pick < 63) kind = FK_MAGIC;
        else if (pick < 71) kind = FK_OFFSET;
        else if (pick < 80) kind = FK_BIG;
        else kind = FK_UNSUP;
      end
      file_count++;
      calm_in = ($urandom_range(0, 4) == 0);

      w     = $urandom_range(1, 5);
      mag   = $urandom_range(1, 4);
      h     = $urandom_range(0, 1) ? -mag : mag;
      depth = $urandom_range(0, 1) ? BPP_32 : BPP_24;
      ofs   = $urandom_range(0, 1) ? HDR_LEN : HDR_LEN + $urandom_range(1, 4);
      comp  = '0;

      case (kind)
        FK_MAGIC: begin
          file_bytes.delete();
          if ($urandom_range(0, 1)) begin
            do b = $urandom_range(0, 255); while (b == MAGIC_B);
            file_bytes.push_back(b);
          end else begin
            file_bytes.push_back(MAGIC_B);
            do b = $urandom_range(0, 255); while (b == MAGIC_M);
            file_bytes.push_back(b);
          end
          push_random($urandom_range(0, 4));
          cut = file_bytes.size() - 1;
        end
        FK_OFFSET: begin
          ofs = $urandom_range(0, HDR_LEN - 1);
          build_header(ofs, w, h, depth, comp);
          push_random($urandom_range(0, 4));
          cut = file_bytes.size() - 1;
        end
        FK_UNSUP: begin
          case (unsup_count % DEFECT_KINDS)
            0: comp = $urandom_range(0, 1) ? $urandom_range(1, 3) : ($urandom | 32'h1000_0000);
            1: begin
              do begin
                depth = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
              end while (depth == BPP_24 || depth == BPP_32);
            end
            2: w = '0;
            3: w = $urandom | 32'h8000_0000;
            4: w = $urandom_range(DEF_MAX_WIDTH + 1, 32'h7FFF_FFFF);
            5: h = '0;
            6: h = 32'h8000_0000;
            7: h = $urandom_range(DEF_MAX_HEIGHT + 1, 32'h7FFF_FFFF);
            default: h = -$urandom_range(DEF_MAX_HEIGHT + 1, 32'h7FFF_FFFF);
          endcase
          unsup_count++;
          build_header(ofs, w, h, depth, comp);
          push_random($urandom_range(0, 4));
          cut = file_bytes.size() - 1;
        end
        FK_BIG: begin
          // largest sizes only ever run a short way before end of file
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            w = DEF_MAX_WIDTH;
          end else if (pick == 1) begin
            w = $urandom_range(1, 3);
            h = $urandom_range(0, 1) ? -DEF_MAX_HEIGHT : DEF_MAX_HEIGHT;
          end else begin
            ofs = $urandom | 32'h0000_0100;
          end
          build_header(ofs, w, h, depth, comp);
          if (pick == 2) begin
            push_random($urandom_range(0, 20));
          end else begin
            push_random(ofs - HDR_LEN);
            push_random($urandom_range(0, 150));
          end
          cut = file_bytes.size() - 1;
        end
        default: begin
          build_header(ofs, w, h, depth, comp);
          push_random(ofs - HDR_LEN);
          row_bytes = ((w * depth + 31) / 32) * 4;
          push_random(mag * row_bytes);
          if (kind == FK_TRUNC) begin
            cut = $urandom_range(0, file_bytes.size() - 2);
          end else begin
            if ($urandom_range(0, 1)) push_random($urandom_range(1, 3));
            cut = file_bytes.size() - 1;
          end
        end
      endcase

      send_file(cut);
      sent_bytes += cut + 1;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bmp_pixel_stream_decoder.f =====
sv/bmpd_pkg.sv
sv/bmpd_res_fifo.sv
sv/bmp_pixel_stream_decoder.sv
dv/tb_bmp_pixel_stream_decoder.sv
